/* design/alr_pkg.sv */
// ----------------------------------------------------------------------------
// alr_pkg
// Shared types and constants for the antialiased line rasterizer.
// ----------------------------------------------------------------------------
package alr_pkg;

	// RGB332 pixel color width
	localparam int COLOR_W = 8;

	// Request codes on the cmd port
	localparam logic CMD_START = 1'b0;

	// Back end sequencer states
	typedef enum logic [1:0] {
		B_FETCH,
		B_DIV,
		B_EMIT0,
		B_EMIT1
	} back_state_t;

endpackage

/* design/alr_front.sv */
// ----------------------------------------------------------------------------
// alr_front
// Classifies incoming requests and sets up start requests: major axis,
// endpoint ordering, major extent and minor magnitude and sign.
// ----------------------------------------------------------------------------
module alr_front #(
	parameter int CW = 10
) (
	input  logic                                  cmd,
	input  logic [CW-1:0]                         x_start,
	input  logic [CW-1:0]                         y_start,
	input  logic [CW-1:0]                         x_stop,
	input  logic [CW-1:0]                         y_stop,
	input  logic [alr_pkg::COLOR_W-1:0]           line_color,
	output logic [6*CW+2+alr_pkg::COLOR_W:0]      entry
);

	logic          is_start;
	logic [CW-1:0] adx, ady;
	logic          steep;
	logic [CW-1:0] sa1, sb1, sa2, sb2;
	logic          swap;
	logic [CW-1:0] ma1, mi1, ma2, mi2;
	logic [CW-1:0] dmaj, mag;
	logic          neg;

	assign is_start = (cmd == alr_pkg::CMD_START);

	// absolute deltas; equal deltas count as steep
	assign adx   = (x_stop > x_start) ? (x_stop - x_start) : (x_start - x_stop);
	assign ady   = (y_stop > y_start) ? (y_stop - y_start) : (y_start - y_stop);
	assign steep = !(adx > ady);

	// map to major/minor axes
	assign sa1 = steep ? y_start : x_start;
	assign sb1 = steep ? x_start : y_start;
	assign sa2 = steep ? y_stop  : x_stop;
	assign sb2 = steep ? x_stop  : y_stop;

	// order so the major coordinate increases
	assign swap = (sa2 < sa1);
	assign ma1  = swap ? sa2 : sa1;
	assign mi1  = swap ? sb2 : sb1;
	assign ma2  = swap ? sa1 : sa2;
	assign mi2  = swap ? sb1 : sb2;

	// major extent, minor magnitude and direction
	assign dmaj = ma2 - ma1;
	assign neg  = (mi2 < mi1);
	assign mag  = neg ? (mi1 - mi2) : (mi2 - mi1);

	assign entry = {is_start, steep, neg, ma1, mi1, ma2, mi2, dmaj, mag, line_color};

endmodule

/* design/alr_cmd_q.sv */
// ----------------------------------------------------------------------------
// alr_cmd_q
// Two-entry request queue between the front end and the back end.
// ----------------------------------------------------------------------------
module alr_cmd_q #(
	parameter int W = 71
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         q_full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         q_empty
);

	logic [W-1:0] mem_q [0:1];
	logic         wr_q, rd_q;
	logic [1:0]   count_q;
	logic         do_wr, do_rd;

	assign q_full  = (count_q == 2'd2);
	assign q_empty = (count_q == 2'd0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_data = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_q <= !wr_q;
			end
			if (do_rd) begin
				rd_q <= !rd_q;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

/* design/alr_div.sv */
// ----------------------------------------------------------------------------
// alr_div
// Gradient divider: (mag << FW) / dmaj with mag <= dmaj, one quotient bit
// per cycle. Zero extent gives 0, equal operands give exactly 1.0.
// ----------------------------------------------------------------------------
module alr_div #(
	parameter int CW = 10,
	parameter int FW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [CW-1:0] dividend,
	input  logic [CW-1:0] divisor,
	output logic          done,
	output logic [FW:0]   quo
);

	localparam int CNT_W = $clog2(FW + 1);

	logic [CW-1:0]    rem_q;
	logic [CW-1:0]    dvs_q;
	logic [FW:0]      quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [CW:0]      rs;
	logic             ge;

	// one restoring step
	assign rs = {rem_q, 1'b0};
	assign ge = (rs >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			rem_q <= dividend;
			dvs_q <= divisor;
			cnt_q <= CNT_W'(FW);
			if (divisor == '0) begin
				quo_q  <= '0;
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else if (dividend == divisor) begin
				quo_q  <= (FW+1)'(1) << FW;
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				quo_q  <= '0;
				busy_q <= 1'b1;
				done_q <= 1'b0;
			end
		end else if (busy_q) begin
			rem_q <= ge ? CW'(rs - {1'b0, dvs_q}) : rs[CW-1:0];
			quo_q <= {quo_q[FW-1:0], ge};
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* design/alr_back.sv */
// ----------------------------------------------------------------------------
// alr_back
// Line walker: takes queued requests, runs the gradient divider on start,
// steps the minor accumulator on ticks, and emits pixel pairs one pixel at
// a time through an output register.
// ----------------------------------------------------------------------------
module alr_back #(
	parameter int CW = 10,
	parameter int FW = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	input  logic [6*CW+2+alr_pkg::COLOR_W:0]  q_data,
	output logic                              q_pop,
	input  logic                              pop,
	output logic                              empty,
	output logic [CW:0]                       pix_x,
	output logic [CW:0]                       pix_y,
	output logic [alr_pkg::COLOR_W-1:0]       pix_color,
	output logic                              last
);

	localparam logic [FW:0] ONE  = (FW+1)'(1) << FW;
	localparam logic [FW:0] HALF = (FW+1)'(1) << (FW - 1);

	// scale each RGB332 channel by n / 2^FW, truncating
	function automatic logic [alr_pkg::COLOR_W-1:0] scale_color(
		input logic [alr_pkg::COLOR_W-1:0] c,
		input logic [FW:0]                 n
	);
		logic [FW+3:0] pr, pg, pb;
		pr = (FW+4)'(c[7:5]) * (FW+4)'(n);
		pg = (FW+4)'(c[4:2]) * (FW+4)'(n);
		pb = (FW+4)'(c[1:0]) * (FW+4)'(n);
		return {pr[FW+2:FW], pg[FW+2:FW], pb[FW+1:FW]};
	endfunction

	// queue head fields
	logic                        hd_start, hd_steep, hd_neg;
	logic [CW-1:0]               hd_ma1, hd_mi1, hd_ma2, hd_mi2, hd_dmaj, hd_mag;
	logic [alr_pkg::COLOR_W-1:0] hd_color;

	assign {hd_start, hd_steep, hd_neg, hd_ma1, hd_mi1, hd_ma2, hd_mi2,
		hd_dmaj, hd_mag, hd_color} = q_data;

	alr_pkg::back_state_t state_q, state_d;

	// line state
	logic                        active_q, steep_q, end_pend_q;
	logic [CW-1:0]               major_pos_q, major_end_q, minor_end_q;
	logic [CW+FW-1:0]            acc_q;
	logic [FW+1:0]               slope_q;
	logic [alr_pkg::COLOR_W-1:0] color_q;
	// start setup held across the division
	logic [CW-1:0]               mi1_q;
	logic                        neg_q;
	// pending pixel pair
	logic [CW-1:0]               pr_maj_q, pr_min_q;
	logic [FW:0]                 pr_cov0_q, pr_cov1_q;
	logic                        pr_last_q;
	// output register
	logic                        ovalid_q;
	logic [CW:0]                 ox_q, oy_q;
	logic [alr_pkg::COLOR_W-1:0] ocolor_q;
	logic                        olast_q;

	logic          div_start, div_done;
	logic [FW:0]   div_quo;
	logic          out_free, out_load, emit_hi;
	logic [FW+1:0] slope_new;
	logic [CW+FW-1:0] acc_new, acc_step;
	logic [CW-1:0] ip, pos_inc;
	logic [FW-1:0] fp;
	logic          fin_end, fin_int;
	logic [CW:0]   e_maj, e_min;

	alr_div #(
		.CW(CW),
		.FW(FW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (hd_mag),
		.divisor  (hd_dmaj),
		.done     (div_done),
		.quo      (div_quo)
	);

	// gradient and first accumulator value on start
	assign slope_new = neg_q ? (FW+2)'(-{1'b0, div_quo}) : {1'b0, div_quo};
	assign acc_new   = {mi1_q, FW'(0)} + {{(CW-2){slope_new[FW+1]}}, slope_new};

	// tick arithmetic
	assign ip       = acc_q[CW+FW-1:FW];
	assign fp       = acc_q[FW-1:0];
	assign pos_inc  = major_pos_q + CW'(1);
	assign fin_end  = ({1'b0, major_end_q} <= ({1'b0, major_pos_q} + (CW+1)'(1)));
	assign fin_int  = (({1'b0, pos_inc} + (CW+1)'(1)) >= {1'b0, major_end_q});
	assign acc_step = acc_q + {{(CW-2){slope_q[FW+1]}}, slope_q};

	assign out_free = !ovalid_q || pop;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			alr_pkg::B_FETCH: begin
				if (!q_empty) begin
					if (hd_start) begin
						state_d = alr_pkg::B_DIV;
					end else if (active_q) begin
						state_d = alr_pkg::B_EMIT0;
					end
				end
			end
			alr_pkg::B_DIV: begin
				if (div_done) begin
					state_d = alr_pkg::B_EMIT0;
				end
			end
			alr_pkg::B_EMIT0: begin
				if (out_free) begin
					state_d = alr_pkg::B_EMIT1;
				end
			end
			alr_pkg::B_EMIT1: begin
				if (out_free) begin
					state_d = alr_pkg::B_FETCH;
				end
			end
			default: state_d = alr_pkg::B_FETCH;
		endcase
	end

	// sequencer outputs
	always_comb begin
		q_pop     = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		emit_hi   = 1'b0;
		case (state_q)
			alr_pkg::B_FETCH: begin
				q_pop     = !q_empty;
				div_start = !q_empty && hd_start;
			end
			alr_pkg::B_EMIT0: begin
				out_load = out_free;
			end
			alr_pkg::B_EMIT1: begin
				out_load = out_free;
				emit_hi  = 1'b1;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= alr_pkg::B_FETCH;
		end else begin
			state_q <= state_d;
		end
	end

	// line state and pixel pair setup
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			steep_q     <= 1'b0;
			end_pend_q  <= 1'b0;
			major_pos_q <= '0;
			major_end_q <= '0;
			minor_end_q <= '0;
			acc_q       <= '0;
			slope_q     <= '0;
			color_q     <= '0;
			mi1_q       <= '0;
			neg_q       <= 1'b0;
			pr_maj_q    <= '0;
			pr_min_q    <= '0;
			pr_cov0_q   <= '0;
			pr_cov1_q   <= '0;
			pr_last_q   <= 1'b0;
		end else if (q_pop) begin
			if (hd_start) begin
				// restart abandons any line in progress
				active_q    <= 1'b0;
				end_pend_q  <= 1'b0;
				steep_q     <= hd_steep;
				color_q     <= hd_color;
				major_pos_q <= hd_ma1;
				major_end_q <= hd_ma2;
				minor_end_q <= hd_mi2;
				mi1_q       <= hd_mi1;
				neg_q       <= hd_neg;
				pr_maj_q    <= hd_ma1;
				pr_min_q    <= hd_mi1;
			end else if (active_q && end_pend_q) begin
				// second endpoint pair
				end_pend_q <= 1'b0;
				if (fin_end) begin
					active_q <= 1'b0;
				end
				pr_maj_q  <= major_end_q;
				pr_min_q  <= minor_end_q;
				pr_cov0_q <= HALF;
				pr_cov1_q <= '0;
				pr_last_q <= fin_end;
			end else if (active_q) begin
				// interior column
				major_pos_q <= pos_inc;
				acc_q       <= acc_step;
				if (fin_int) begin
					active_q <= 1'b0;
				end
				pr_maj_q  <= pos_inc;
				pr_min_q  <= ip;
				pr_cov0_q <= ONE - {1'b0, fp};
				pr_cov1_q <= {1'b0, fp};
				pr_last_q <= fin_int;
			end
		end else if (state_q == alr_pkg::B_DIV && div_done) begin
			// first endpoint pair
			slope_q    <= slope_new;
			acc_q      <= acc_new;
			active_q   <= 1'b1;
			end_pend_q <= 1'b1;
			pr_cov0_q  <= HALF;
			pr_cov1_q  <= '0;
			pr_last_q  <= 1'b0;
		end
	end

	// pixel of the pair being emitted
	assign e_maj = {1'b0, pr_maj_q};
	assign e_min = emit_hi ? ({1'b0, pr_min_q} + (CW+1)'(1)) : {1'b0, pr_min_q};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_load) begin
			ovalid_q <= 1'b1;
		end else if (pop) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ox_q     <= steep_q ? e_min : e_maj;
			oy_q     <= steep_q ? e_maj : e_min;
			ocolor_q <= scale_color(color_q, emit_hi ? pr_cov1_q : pr_cov0_q);
			olast_q  <= emit_hi && pr_last_q;
		end
	end

	assign empty     = !ovalid_q;
	assign pix_x     = ox_q;
	assign pix_y     = oy_q;
	assign pix_color = ocolor_q;
	assign last      = olast_q;

`ifndef SYNTHESIS
	// the divider only finishes while the sequencer waits on it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == alr_pkg::B_DIV))
		else $error("divider finished outside of the division wait");

	// a pending end pair implies a live line
	a_pend_active: assert property (@(posedge clk) disable iff (!arst_n)
		end_pend_q |-> active_q)
		else $error("end pair pending on an inactive line");

	// the final pixel of a line is only emitted once the line is closed
	a_last_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == alr_pkg::B_EMIT1 && pr_last_q) |-> !active_q)
		else $error("final pixel emitted while the line is still active");

	// a start request always launches the divider
	a_start_div: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && hd_start) |=> (state_q == alr_pkg::B_DIV))
		else $error("start request did not enter the division wait");
`endif

endmodule

/* design/antialiased_line_rasterizer.sv */
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer
// Wu antialiased line drawing in RGB332: start requests set up a line,
// tick requests step it one pixel pair at a time.
// ----------------------------------------------------------------------------
//
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------------------
//  request   | push / full        | cmd, x_start, y_start, x_stop, y_stop,
//            |                    | line_color
//  pixel     | empty / pop        | pix_x, pix_y, pix_color, last
//
//  A start request leaves the request queue and waits on the one-bit-per-cycle
//  gradient divider before its first pixel pair is emitted; single-point and
//  45-degree lines skip the division.
//  A tick is a fetch and then one pixel per cycle through the output register
//  while the receiver keeps popping; a tick on an idle block yields nothing.
//  A two-entry request queue holds up to two requests while the pixel side
//  is stalled. Reset clears all line state, the queue and the output register.
//
module antialiased_line_rasterizer #(
	parameter int COORD_BITS = 10,
	parameter int FRAC_BITS  = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic                              cmd,
	input  logic [COORD_BITS-1:0]             x_start,
	input  logic [COORD_BITS-1:0]             y_start,
	input  logic [COORD_BITS-1:0]             x_stop,
	input  logic [COORD_BITS-1:0]             y_stop,
	input  logic [alr_pkg::COLOR_W-1:0]       line_color,
	output logic                              empty,
	input  logic                              pop,
	output logic [COORD_BITS:0]               pix_x,
	output logic [COORD_BITS:0]               pix_y,
	output logic [alr_pkg::COLOR_W-1:0]       pix_color,
	output logic                              last
);

	localparam int EW = 6 * COORD_BITS + 3 + alr_pkg::COLOR_W;

	logic [EW-1:0] fe_entry;
	logic [EW-1:0] q_data;
	logic          q_empty;
	logic          q_pop;

	// request setup
	alr_front #(
		.CW(COORD_BITS)
	) u_front (
		.cmd        (cmd),
		.x_start    (x_start),
		.y_start    (y_start),
		.x_stop     (x_stop),
		.y_stop     (y_stop),
		.line_color (line_color),
		.entry      (fe_entry)
	);

	// request queue
	alr_cmd_q #(
		.W(EW)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (fe_entry),
		.q_full  (full),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.q_empty (q_empty)
	);

	// line walker and pixel output
	alr_back #(
		.CW(COORD_BITS),
		.FW(FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.pop       (pop),
		.empty     (empty),
		.pix_x     (pix_x),
		.pix_y     (pix_y),
		.pix_color (pix_color),
		.last      (last)
	);

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the antialiased line rasterizer. Start and tick
// requests go in through the push/full queue, and pixels come out through
// empty/pop. A behavioral line stepper in this file predicts the pixels,
// apart from hand-written expectations. A short directed table comes first,
// then random lines in three idle profiles, and a drain with a quiet period ends the run.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int COORD_W = 10;
	localparam int FRAC_W = 16;
	localparam int COLOR_W = alr_pkg::COLOR_W;
	localparam logic CMD_START = alr_pkg::CMD_START;
	localparam int unsigned ONE = 1 << FRAC_W;
	localparam int unsigned HALF = ONE >> 1;
	localparam logic CMD_TICK = ~CMD_START;
	localparam int PREDICTED = -1;
	localparam int ITEMS = 1750;
	localparam int DRAIN_CYCLES = 64;
	localparam int QUIET_LIMIT = 4000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [COORD_W:0] x;
		logic [COORD_W:0] y;
		logic [COLOR_W-1:0] color;
		logic last;
	} pixel_t;

	typedef struct {
		logic c;
		logic [COORD_W-1:0] xs, ys, xe, ye;
		logic [COLOR_W-1:0] col;
		int n_typed;
		pixel_t t0, t1;
	} dir_req_t;

	logic clk;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic cmd = 1'b0;
	logic [COORD_W-1:0] x_start = '0;
	logic [COORD_W-1:0] y_start = '0;
	logic [COORD_W-1:0] x_stop = '0;
	logic [COORD_W-1:0] y_stop = '0;
	logic [COLOR_W-1:0] line_color = '0;
	logic pop = 1'b0;
	logic full, empty, last;
	logic [COORD_W:0] pix_x, pix_y;
	logic [COLOR_W-1:0] pix_color;

	// hand-written expectations travel with the request they belong to
	int req_n_typed = PREDICTED;
	pixel_t req_typed0 = '0;
	pixel_t req_typed1 = '0;

	int tx_idle = 0;
	int rx_idle = 0;
	int mismatches = 0;
	int handshakes = 0;
	int productive_reqs = 0;

	pixel_t pending_pixels[$];
	pixel_t step_pixels[2];
	dir_req_t directed_reqs[$];

	// line stepper state
	logic ln_active = 1'b0;
	logic ln_steep = 1'b0;
	logic ln_end_pending = 1'b0;
	logic [COORD_W-1:0] ln_major_pos = '0;
	logic [COORD_W-1:0] ln_major_end = '0;
	logic [COORD_W-1:0] ln_minor_end = '0;
	logic [COORD_W+FRAC_W-1:0] ln_acc = '0;
	logic signed [17:0] ln_slope = '0;
	logic [COLOR_W-1:0] ln_color = '0;

	antialiased_line_rasterizer #(
		.COORD_BITS(COORD_W),
		.FRAC_BITS(FRAC_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cmd(cmd),
		.x_start(x_start),
		.y_start(y_start),
		.x_stop(x_stop),
		.y_stop(y_stop),
		.line_color(line_color),
		.empty(empty),
		.pop(pop),
		.pix_x(pix_x),
		.pix_y(pix_y),
		.pix_color(pix_color),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// scale each RGB332 channel by n / 2^FRAC_W, truncating
	function automatic logic [COLOR_W-1:0] shade(logic [COLOR_W-1:0] c, int unsigned n);
		logic [31:0] r, g, b;
		r = (32'(c[7:5]) * n) >> FRAC_W;
		g = (32'(c[4:2]) * n) >> FRAC_W;
		b = (32'(c[1:0]) * n) >> FRAC_W;
		return {r[2:0], g[2:0], b[1:0]};
	endfunction

	// map major/minor back to screen axes
	function automatic pixel_t place(int maj, int mnr, logic [COLOR_W-1:0] c, logic l);
		pixel_t p;
		p.x = ln_steep ? 11'(mnr) : 11'(maj);
		p.y = ln_steep ? 11'(maj) : 11'(mnr);
		p.color = c;
		p.last = l;
		return p;
	endfunction

	// advance the line stepper by one request; pixels land in step_pixels
	function automatic int rasterize_step(logic c, logic [COORD_W-1:0] xa, ya, xb, yb,
			logic [COLOR_W-1:0] col);
		int x1, y1, x2, y2, adx, ady, ma1, mi1, ma2, mi2, t, dmaj, dmin;
		int unsigned mag, q;
		logic [COORD_W-1:0] ip;
		logic [FRAC_W-1:0] fp;
		logic fin;
		if (c == CMD_START) begin
			x1 = int'(xa);
			y1 = int'(ya);
			x2 = int'(xb);
			y2 = int'(yb);
			adx = (x2 > x1) ? x2 - x1 : x1 - x2;
			ady = (y2 > y1) ? y2 - y1 : y1 - y2;
			// equal deltas count as steep
			ln_steep = !(adx > ady);
			if (ln_steep) begin
				ma1 = y1; mi1 = x1; ma2 = y2; mi2 = x2;
			end else begin
				ma1 = x1; mi1 = y1; ma2 = x2; mi2 = y2;
			end
			if (ma2 < ma1) begin
				t = ma1; ma1 = ma2; ma2 = t;
				t = mi1; mi1 = mi2; mi2 = t;
			end
			dmaj = ma2 - ma1;
			dmin = mi2 - mi1;
			mag = (dmin < 0) ? -dmin : dmin;
			// a single point has no gradient
			q = (dmaj > 0) ? (mag << FRAC_W) / dmaj : 0;
			ln_slope = 18'(q);
			if (dmin < 0)
				ln_slope = -ln_slope;
			ln_color = col;
			ln_major_pos = 10'(ma1);
			ln_major_end = 10'(ma2);
			ln_minor_end = 10'(mi2);
			ln_acc = 26'(mi1 << FRAC_W) + {{8{ln_slope[17]}}, ln_slope};
			ln_active = 1'b1;
			ln_end_pending = 1'b1;
			step_pixels[0] = place(ma1, mi1, shade(col, HALF), 1'b0);
			step_pixels[1] = place(ma1, mi1 + 1, '0, 1'b0);
			return 2;
		end
		if (!ln_active)
			return 0;
		// second endpoint comes right after the start
		if (ln_end_pending) begin
			fin = int'(ln_major_end) <= int'(ln_major_pos) + 1;
			ln_end_pending = 1'b0;
			if (fin)
				ln_active = 1'b0;
			step_pixels[0] = place(int'(ln_major_end), int'(ln_minor_end),
				shade(ln_color, HALF), 1'b0);
			step_pixels[1] = place(int'(ln_major_end), int'(ln_minor_end) + 1, '0, fin);
			return 2;
		end
		// interior column
		ip = ln_acc[COORD_W+FRAC_W-1:FRAC_W];
		fp = ln_acc[FRAC_W-1:0];
		ln_major_pos = ln_major_pos + 1'b1;
		fin = int'(ln_major_pos) + 1 >= int'(ln_major_end);
		step_pixels[0] = place(int'(ln_major_pos), int'(ip), shade(ln_color, ONE - fp), 1'b0);
		step_pixels[1] = place(int'(ln_major_pos), int'(ip) + 1, shade(ln_color, fp), fin);
		ln_acc = ln_acc + {{8{ln_slope[17]}}, ln_slope};
		if (fin)
			ln_active = 1'b0;
		return 2;
	endfunction

	function automatic pixel_t px(int x, int y, logic [COLOR_W-1:0] c, logic l);
		pixel_t p;
		p.x = 11'(x);
		p.y = 11'(y);
		p.color = c;
		p.last = l;
		return p;
	endfunction

	function automatic dir_req_t row(logic c, int xs, int ys, int xe, int ye,
			logic [COLOR_W-1:0] col, int n_typed, pixel_t t0, pixel_t t1);
		dir_req_t r;
		r.c = c;
		r.xs = 10'(xs);
		r.ys = 10'(ys);
		r.xe = 10'(xe);
		r.ye = 10'(ye);
		r.col = col;
		r.n_typed = n_typed;
		r.t0 = t0;
		r.t1 = t1;
		return r;
	endfunction

	// drive one request, with random gaps in front, and hold it until taken
	task automatic send_req(logic c, logic [COORD_W-1:0] xs, ys, xe, ye,
			logic [COLOR_W-1:0] col, int n_typed, pixel_t t0, pixel_t t1);
		while ($urandom_range(99) < tx_idle) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		cmd <= c;
		x_start <= xs;
		y_start <= ys;
		x_stop <= xe;
		y_stop <= ye;
		line_color <= col;
		req_n_typed <= n_typed;
		req_typed0 <= t0;
		req_typed1 <= t1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_tick();
		send_req(CMD_TICK, 10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
			8'($urandom), PREDICTED, '0, '0);
	endtask

	// one random line: mostly short and complete, sometimes cut off by a restart
	task automatic draw_random_line();
		int dmaj, dmin, ma1, mi1, ticks;
		logic [COORD_W-1:0] a0, a1, b0, b1, t;
		logic [COLOR_W-1:0] col;
		bit cut;
		if ($urandom_range(29) == 0)
			dmaj = $urandom_range(200, 16);
		else
			dmaj = $urandom_range(15, 0);
		case ($urandom_range(3))
			0: dmin = 0;
			1: dmin = dmaj;
			default: dmin = $urandom_range(dmaj, 0);
		endcase
		ma1 = $urandom_range(1023 - dmaj, 0);
		mi1 = $urandom_range(1023 - dmin, 0);
		a0 = 10'(ma1);
		a1 = 10'(ma1 + dmaj);
		b0 = 10'(mi1);
		b1 = 10'(mi1 + dmin);
		// falling minor axis
		if ($urandom_range(1)) begin
			t = b0; b0 = b1; b1 = t;
		end
		// endpoints given in reverse order
		if ($urandom_range(1)) begin
			t = a0; a0 = a1; a1 = t;
			t = b0; b0 = b1; b1 = t;
		end
		col = 8'($urandom);
		if ($urandom_range(1))
			send_req(CMD_START, b0, a0, b1, a1, col, PREDICTED, '0, '0);
		else
			send_req(CMD_START, a0, b0, a1, b1, col, PREDICTED, '0, '0);
		ticks = (dmaj > 1) ? dmaj : 1;
		cut = ($urandom_range(7) == 0);
		if (cut)
			ticks = $urandom_range(ticks - 1, 0);
		productive_reqs += 1 + ticks;
		repeat (ticks)
			send_tick();
		// stray ticks on an idle block
		if (!cut && $urandom_range(5) == 0)
			repeat ($urandom_range(3, 1))
				send_tick();
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(negedge clk);
		while (pending_pixels.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(int tx_pct, int rx_pct);
		int target;
		tx_idle = tx_pct;
		rx_idle = rx_pct;
		target = productive_reqs + ITEMS / 3;
		while (productive_reqs < target)
			draw_random_line();
		wait_drained();
	endtask

	// receiver back-pressure
	always @(negedge clk)
		pop <= ($urandom_range(99) >= rx_idle);

	// accept pixels against the oldest expectation, then predict new requests
	always @(posedge clk) begin : monitor
		pixel_t got, want;
		int n;
		if (arst_n) begin
			if (pop && !empty) begin
				handshakes++;
				got = {pix_x, pix_y, pix_color, last};
				if (pending_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected pixel x=%0d y=%0d color=%02h last=%0b",
							got.x, got.y, got.color, got.last);
				end else begin
					want = pending_pixels.pop_front();
					if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
							got.last !== want.last) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$write("pixel mismatch: expected x=%0d y=%0d color=%02h last=%0b,",
								want.x, want.y, want.color, want.last);
							$display(" got x=%0d y=%0d color=%02h last=%0b",
								got.x, got.y, got.color, got.last);
						end
					end
				end
			end
			if (push && !full) begin
				handshakes++;
				n = rasterize_step(cmd, x_start, y_start, x_stop, y_stop, line_color);
				if (req_n_typed == PREDICTED) begin
					for (int i = 0; i < n; i++)
						pending_pixels.push_back(step_pixels[i]);
				end else begin
					if (req_n_typed > 0)
						pending_pixels.push_back(req_typed0);
					if (req_n_typed > 1)
						pending_pixels.push_back(req_typed1);
				end
			end
		end
	end

	// end the run if no request or pixel moves for too long
	initial begin : watchdog
		int seen, quiet;
		seen = 0;
		quiet = 0;
		forever begin
			@(negedge clk);
			if (handshakes != seen) begin
				seen = handshakes;
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= QUIET_LIMIT)
				break;
		end
		$display("watchdog: no handshake for %0d cycles, %0d pixels outstanding",
			QUIET_LIMIT, pending_pixels.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		dir_req_t r;
		// tick before any line, single points at both corners, then
		// full-width, diagonal, steep, short and reversed lines with restarts
		directed_reqs.push_back(row(CMD_TICK, 0, 0, 0, 0, 8'h00, 0, '0, '0));
		directed_reqs.push_back(row(CMD_START, 0, 0, 0, 0, 8'hFF, 2,
			px(0, 0, 8'h6D, 1'b0), px(1, 0, 8'h00, 1'b0)));
		directed_reqs.push_back(row(CMD_TICK, 0, 0, 0, 0, 8'h00, 2,
			px(0, 0, 8'h6D, 1'b0), px(1, 0, 8'h00, 1'b1)));
		directed_reqs.push_back(row(CMD_TICK, 0, 0, 0, 0, 8'h00, 0, '0, '0));
		directed_reqs.push_back(row(CMD_START, 1023, 1023, 1023, 1023, 8'hFF, 2,
			px(1023, 1023, 8'h6D, 1'b0), px(1024, 1023, 8'h00, 1'b0)));
		directed_reqs.push_back(row(CMD_TICK, 0, 0, 0, 0, 8'h00, 2,
			px(1023, 1023, 8'h6D, 1'b0), px(1024, 1023, 8'h00, 1'b1)));
		directed_reqs.push_back(row(CMD_START, 0, 0, 1023, 0, 8'hE0, PREDICTED, '0, '0));
		repeat (3)
			directed_reqs.push_back(row(CMD_TICK, 0, 0, 0, 0, 8'h00, PREDICTED, '0, '0));
		directed_reqs.push_back(row(CMD_START, 1023, 1023, 0, 0, 8'h1C, PREDICTED, '0, '0));
		repeat (2)
			directed_reqs.push_back(row(CMD_TICK, 0, 0, 0, 0, 8'h00, PREDICTED, '0, '0));
		directed_reqs.push_back(row(CMD_START, 10, 0, 3, 1023, 8'h03, PREDICTED, '0, '0));
		directed_reqs.push_back(row(CMD_TICK, 0, 0, 0, 0, 8'h00, PREDICTED, '0, '0));
		directed_reqs.push_back(row(CMD_START, 5, 5, 6, 5, 8'hFF, PREDICTED, '0, '0));
		repeat (2)
			directed_reqs.push_back(row(CMD_TICK, 0, 0, 0, 0, 8'h00, PREDICTED, '0, '0));
		directed_reqs.push_back(row(CMD_START, 104, 203, 100, 200, 8'h92, PREDICTED, '0, '0));
		repeat (5)
			directed_reqs.push_back(row(CMD_TICK, 0, 0, 0, 0, 8'h00, PREDICTED, '0, '0));
		directed_reqs.push_back(row(CMD_START, 0, 1023, 1023, 0, 8'hFF, PREDICTED, '0, '0));

		// reset
		repeat (11)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table, no idling
		foreach (directed_reqs[i]) begin
			r = directed_reqs[i];
			send_req(r.c, r.xs, r.ys, r.xe, r.ye, r.col, r.n_typed, r.t0, r.t1);
		end
		wait_drained();

		// random lines under three idle profiles, draining after each
		run_phase(21, 45);
		run_phase(45, 21);
		run_phase(0, 0);

		// quiet period to catch stray pixels
		repeat (DRAIN_CYCLES)
			@(negedge clk);
		if (mismatches == 0 && pending_pixels.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* files.f */
design/alr_pkg.sv
design/alr_front.sv
design/alr_cmd_q.sv
design/alr_div.sv
design/alr_back.sv
design/antialiased_line_rasterizer.sv
dv/tb_top.sv
